>>> hw/rtl/lpht_pkg.sv
// Shared types and constants for the linear probing hash table.
// No dependencies; used by lpht_ctrl and linear_probe_hash_table_core.
`timescale 1ns / 1ps

package lpht_pkg;

  // table depth; the home slot is key modulo this, so keep it a power of two
  localparam int unsigned TableSize = 16;
  localparam int unsigned SlotW     = (TableSize > 1) ? $clog2(TableSize) : 1;
  localparam int unsigned KeyW      = 31;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned SlotOutW  = 4;

  typedef enum logic {
    OpInsert = 1'b0,
    OpFind   = 1'b1
  } op_e;

  typedef enum logic [StatusW-1:0] {
    StInserted = 2'd0,
    StFull     = 2'd1,
    StFound    = 2'd2,
    StNotFound = 2'd3
  } status_e;

  typedef struct packed {
    logic             we;
    logic [SlotW-1:0] addr;
    logic [KeyW-1:0]  wdata;
  } ram_req_t;

  typedef struct packed {
    logic             valid;
    status_e          status;
    logic [SlotW-1:0] slot;
  } res_t;

  function automatic logic [SlotW-1:0] next_slot(logic [SlotW-1:0] s);
    logic [SlotW-1:0] n;
    n = (s == SlotW'(TableSize - 1)) ? '0 : s + SlotW'(1);
    return n;
  endfunction

  function automatic logic [SlotOutW-1:0] slot_out(logic [SlotW-1:0] s);
    logic [SlotW+SlotOutW-1:0] ext;
    ext = {{SlotOutW{1'b0}}, s};
    return ext[SlotOutW-1:0];
  endfunction

endpackage

>>> hw/rtl/lpht_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module lpht_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/lpht_ctrl.sv
// Probe sequencer: holds the slot valid flags and walks the key memory.
// Depends on lpht_pkg; drives one lpht_ram port.
`timescale 1ns / 1ps

module lpht_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic                      operation_i,
  input  logic [lpht_pkg::KeyW-1:0] key_i,
  output lpht_pkg::ram_req_t        ram_req_o,
  input  logic [lpht_pkg::KeyW-1:0] ram_rdata_i,
  output lpht_pkg::res_t            res_o,
  input  logic                      res_ready_i
);
  import lpht_pkg::*;

  typedef enum logic [1:0] {
    SIdle,
    SInsert,
    SFind,
    SDone
  } state_e;

  localparam logic [SlotW-1:0] LastIdx = SlotW'(TableSize - 1);

  state_e               state_q, state_d;
  logic [KeyW-1:0]      key_q, key_d;
  logic [SlotW-1:0]     pos_q, pos_d;
  logic [SlotW-1:0]     idx_q, idx_d;
  logic                 issue_q, issue_d;
  logic                 cmp_act_q, cmp_act_d;
  logic [SlotW-1:0]     cmp_pos_q, cmp_pos_d;
  logic                 cmp_last_q, cmp_last_d;
  logic [TableSize-1:0] valid_q, valid_d;
  status_e              status_q, status_d;
  logic [SlotW-1:0]     slot_q, slot_d;

  always_comb begin
    state_d    = state_q;
    key_d      = key_q;
    pos_d      = pos_q;
    idx_d      = idx_q;
    issue_d    = issue_q;
    cmp_act_d  = 1'b0;
    cmp_pos_d  = cmp_pos_q;
    cmp_last_d = cmp_last_q;
    valid_d    = valid_q;
    status_d   = status_q;
    slot_d     = slot_q;
    ram_req_o  = '{we: 1'b0, addr: pos_q, wdata: key_q};

    case (state_q)
      SIdle: begin
        if (in_valid_i) begin
          key_d   = key_i;
          pos_d   = SlotW'(key_i % TableSize);
          idx_d   = '0;
          issue_d = 1'b0;
          if (op_e'(operation_i) == OpInsert) begin
            state_d = SInsert;
          end else begin
            state_d = SFind;
            issue_d = 1'b1;
          end
        end
      end
      SInsert: begin
        if (!valid_q[pos_q]) begin
          ram_req_o.we   = 1'b1;
          valid_d[pos_q] = 1'b1;
          status_d       = StInserted;
          slot_d         = pos_q;
          state_d        = SDone;
        end else if (idx_q == LastIdx) begin
          status_d = StFull;
          slot_d   = '0;
          state_d  = SDone;
        end else begin
          pos_d = next_slot(pos_q);
          idx_d = idx_q + SlotW'(1);
        end
      end
      SFind: begin
        // read of pos_q issued now, compared next cycle
        cmp_act_d  = issue_q;
        cmp_pos_d  = pos_q;
        cmp_last_d = (idx_q == LastIdx);
        if (issue_q) begin
          pos_d = next_slot(pos_q);
          idx_d = idx_q + SlotW'(1);
          if (idx_q == LastIdx) begin
            issue_d = 1'b0;
          end
        end
        if (cmp_act_q) begin
          if (valid_q[cmp_pos_q] && (ram_rdata_i == key_q)) begin
            status_d  = StFound;
            slot_d    = cmp_pos_q;
            state_d   = SDone;
            issue_d   = 1'b0;
            cmp_act_d = 1'b0;
          end else if (cmp_last_q) begin
            status_d = StNotFound;
            slot_d   = '0;
            state_d  = SDone;
          end
        end
      end
      SDone: begin
        if (res_ready_i) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= SIdle;
      issue_q   <= 1'b0;
      cmp_act_q <= 1'b0;
      valid_q   <= '0;
    end else begin
      state_q   <= state_d;
      issue_q   <= issue_d;
      cmp_act_q <= cmp_act_d;
      valid_q   <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    pos_q      <= pos_d;
    idx_q      <= idx_d;
    cmp_pos_q  <= cmp_pos_d;
    cmp_last_q <= cmp_last_d;
    status_q   <= status_d;
    slot_q     <= slot_d;
  end

  assign in_ready_o   = (state_q == SIdle);
  assign res_o.valid  = (state_q == SDone);
  assign res_o.status = status_q;
  assign res_o.slot   = slot_q;

  a_write_only_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req_o.we |-> (state_q == SInsert))
    else $error("key memory written outside insert");

  a_found_is_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.status == StFound)) |-> valid_q[res_o.slot])
    else $error("found slot is not valid");

  a_inserted_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req_o.we |=> valid_q[$past(ram_req_o.addr)])
    else $error("insert did not set valid flag");

  a_compare_only_in_find: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmp_act_q |-> (state_q == SFind))
    else $error("compare stage active outside find");

endmodule

>>> hw/rtl/linear_probe_hash_table_core.sv
// Top level of the linear probing hash table: sequencer, key memory, output word register.
// Depends on lpht_pkg, lpht_ctrl and lpht_ram.
`timescale 1ns / 1ps

// One request word (insert or find of a 31-bit key) is handled at a time and gives one
// result word. The home slot is the key modulo the table size; the key memory is walked
// one slot per cycle from there, wrapping, for at most one lap. A find compares each
// slot's key once its registered read returns, while the next read is already issued.
// The single-port key memory, visited one slot per cycle, sets the probe rate. Valid
// flags are cleared by reset at once, so the block takes requests right after reset.
// A new request is taken while the previous result word still waits in the output
// register.
module linear_probe_hash_table_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          operation_i,
  input  logic [lpht_pkg::KeyW-1:0]     key_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [lpht_pkg::StatusW-1:0]  status_o,
  output logic [lpht_pkg::SlotOutW-1:0] slot_o
);
  import lpht_pkg::*;

  ram_req_t             ram_req;
  logic [KeyW-1:0]      ram_rdata;
  res_t                 res;
  logic                 res_ready;
  logic                 out_valid_q, out_valid_d;
  logic [StatusW-1:0]   status_q, status_d;
  logic [SlotOutW-1:0]  slot_q, slot_d;

  lpht_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .key_i       (key_i),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  lpht_ram #(
    .Width (KeyW),
    .Depth (TableSize)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .addr_i  (ram_req.addr),
    .wdata_i (ram_req.wdata),
    .rdata_o (ram_rdata)
  );

  assign res_ready = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    status_d    = status_q;
    slot_d      = slot_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (res.valid && res_ready) begin
      out_valid_d = 1'b1;
      status_d    = res.status;
      slot_d      = slot_out(res.slot);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    slot_q   <= slot_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign slot_o      = slot_q;

endmodule

>>> dv/tb.sv
// Testbench for linear_probe_hash_table_core: directed table walk, then random insert/find words.
// Results are checked against an in-bench model of the probed key table; depends on lpht_pkg.
`timescale 1ns / 1ps

module tb;
  import lpht_pkg::*;

  localparam int unsigned NumRandom = 1600;
  localparam int unsigned CalmTail  = 200;
  localparam int unsigned TailWait  = 40;
  localparam int unsigned MaxPrints = 50;

  typedef struct packed {
    status_e               status;
    logic [SlotOutW-1:0]   slot;
  } result_t;

  typedef struct {
    op_e                 op;
    logic [KeyW-1:0]     key;
    bit                  typed;
    status_e             status;
    logic [SlotOutW-1:0] slot;
  } row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid;
  logic                 in_ready_o;
  logic                 in_op;
  logic [KeyW-1:0]      in_key;
  logic                 out_valid_o;
  logic                 out_ready;
  logic [StatusW-1:0]   status_o;
  logic [SlotOutW-1:0]  slot_o;

  logic [KeyW-1:0] key_store [TableSize];
  bit              slot_used [TableSize];
  result_t         pending_results [$];
  row_t            directed_rows [$];
  bit              idle_on;
  int unsigned     err_count;
  int unsigned     stall_left;

  linear_probe_hash_table_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .operation_i (in_op),
    .key_i       (in_key),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .status_o    (status_o),
    .slot_o      (slot_o)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  task automatic flag_error(input string msg);
    if (err_count < MaxPrints) begin
      $display("ERROR @%0t: %s", $time, msg);
    end
    err_count++;
  endtask

  // walks the probe path from the home slot, updating the table on insert
  function automatic result_t probe_table(input op_e op, input logic [KeyW-1:0] k);
    result_t     res;
    int unsigned pos;
    pos = k % TableSize;
    res.status = (op == OpInsert) ? StFull : StNotFound;
    res.slot = '0;
    for (int n = 0; n < TableSize; n++) begin
      if (op == OpInsert) begin
        if (!slot_used[pos]) begin
          key_store[pos] = k;
          slot_used[pos] = 1'b1;
          res.status = StInserted;
          res.slot = SlotOutW'(pos);
          break;
        end
      end else if (slot_used[pos] && key_store[pos] == k) begin
        res.status = StFound;
        res.slot = SlotOutW'(pos);
        break;
      end
      pos = (pos + 1 == TableSize) ? 0 : pos + 1;
    end
    return res;
  endfunction

  task automatic add_row(input op_e op, input logic [KeyW-1:0] k, input bit typed,
                         input status_e st, input logic [SlotOutW-1:0] sl);
    row_t r;
    r.op = op;
    r.key = k;
    r.typed = typed;
    r.status = st;
    r.slot = sl;
    directed_rows.push_back(r);
  endtask

  task automatic send_word(input row_t r);
    int unsigned gap;
    result_t     res;
    @(negedge clk_i);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_op    <= r.op;
    in_key   <= r.key;
    do @(posedge clk_i); while (!in_ready_o);
    res = probe_table(r.op, r.key);
    if (r.typed) begin
      res.status = r.status;
      res.slot = r.slot;
    end
    pending_results.push_back(res);
  endtask

  // output side stalls in bursts
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(1, 19) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin : check_out
    result_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected result word status=%0d slot=%0d", status_o, slot_o));
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) begin
          flag_error($sformatf("status got %0d want %0d", status_o, want.status));
        end
        if (slot_o !== want.slot) begin
          flag_error($sformatf("slot got %0d want %0d", slot_o, want.slot));
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    row_t        r;
    int unsigned pick;
    int unsigned idx;
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    in_op      = OpInsert;
    in_key     = '0;
    out_ready  = 1'b0;
    idle_on    = 1'b1;
    err_count  = 0;
    stall_left = 0;
    for (int i = 0; i < TableSize; i++) begin
      key_store[i] = '0;
      slot_used[i] = 1'b0;
    end
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // empty table, extremes, collisions with wraparound, duplicates, then a full table
    add_row(OpFind,   31'd0,          1'b1, StNotFound, 4'd0);
    add_row(OpInsert, 31'd0,          1'b1, StInserted, 4'd0);
    add_row(OpInsert, 31'd16,         1'b0, StInserted, 4'd0);
    add_row(OpFind,   31'd16,         1'b0, StFound,    4'd0);
    add_row(OpInsert, 31'h7FFF_FFFF,  1'b1, StInserted, 4'd15);
    add_row(OpInsert, 31'd31,         1'b0, StInserted, 4'd0);
    add_row(OpInsert, 31'd31,         1'b0, StInserted, 4'd0);
    add_row(OpFind,   31'd31,         1'b0, StFound,    4'd0);
    add_row(OpFind,   31'd47,         1'b0, StNotFound, 4'd0);
    for (int i = 4; i < 15; i++) begin
      add_row(OpInsert, KeyW'(i) | (KeyW'(i) << 27) | (KeyW'(i & 1) << 14), 1'b0,
              StInserted, 4'd0);
    end
    add_row(OpInsert, 31'd5,          1'b1, StFull,     4'd0);
    add_row(OpFind,   31'h7FFF_FFFF,  1'b0, StFound,    4'd0);
    add_row(OpFind,   31'd1000,       1'b1, StNotFound, 4'd0);
    foreach (directed_rows[i]) send_word(directed_rows[i]);

    // random words: mostly finds of stored keys, near misses on the same home slot
    for (int i = 0; i < NumRandom; i++) begin
      idle_on = (i < NumRandom - CalmTail) && ((i / 150) % 3 != 2);
      pick = $urandom_range(0, 9);
      idx = $urandom_range(0, TableSize - 1);
      r.typed = 1'b0;
      r.status = StInserted;
      r.slot = '0;
      r.op = OpFind;
      r.key = KeyW'($urandom());
      if (pick < 5 && slot_used[idx]) begin
        r.key = key_store[idx];
      end else if (pick < 7 && slot_used[idx]) begin
        r.key = key_store[idx] ^ (KeyW'($urandom_range(1, 27'h7FF_FFFF)) << 4);
      end else if (pick >= 8) begin
        r.op = OpInsert;
      end
      send_word(r);
    end
    @(negedge clk_i);
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (TailWait) @(posedge clk_i);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
